// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified concurrent assertion shorthands.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/kmt_pkg.sv
// ----------------------------------------------------------------------------
// kmt_pkg
// Types and constants shared by the keyed message table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kmt_pkg;

	localparam int SLOTS_DEF        = 16;
	localparam int PAYLOAD_BITS_DEF = 32;

	localparam int KIND_W   = 2;
	localparam int KEY_W    = 32;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 5;

	typedef enum logic [KIND_W-1:0] {
		K_ADD    = 2'd0,
		K_GET    = 2'd1,
		K_REMOVE = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_UPDATED   = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_REMOVED   = 3'd4,
		ST_FULL      = 3'd5,
		ST_REJECTED  = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_RESP
	} state_t;

endpackage

// File: design/kmt_if.sv
// ----------------------------------------------------------------------------
// kmt_if
// Request and response channels of the keyed message table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kmt_req_if import kmt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [KEY_W-1:0]  key;
	logic              key_is_empty_marker;
	logic [DATA_W-1:0] payload_in;

	modport source (output valid, kind, key, key_is_empty_marker, payload_in, input ready);
	modport sink   (input valid, kind, key, key_is_empty_marker, payload_in, output ready);
endinterface

interface kmt_rsp_if import kmt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [DATA_W-1:0]   payload_out;
	logic [COUNT_W-1:0]  valid_count;
	logic [COUNT_W-1:0]  free_count;

	modport source (output valid, status, payload_out, valid_count, free_count, input ready);
	modport sink   (input valid, status, payload_out, valid_count, free_count, output ready);
endinterface

// File: design/keyed_message_table_core.sv
// ----------------------------------------------------------------------------
// keyed_message_table_core
// Fixed-capacity key/payload store with add, get and remove requests.
// ----------------------------------------------------------------------------
// Each request walks all SLOTS entries through the single read port of the
// entry memory, one entry per cycle, looking for the matching key and the
// lowest free slot; S_DECIDE then decides and writes back, and S_RESP loads
// the response register once it is free. The block takes no new request
// until the previous one has loaded its response; the entry-memory scan
// sets how long that takes. The response register lets a new request be
// taken while the previous response still waits. After reset the block
// clears the valid bits of every entry-memory slot and holds req.ready low.
`timescale 1ns / 1ps

module keyed_message_table_core import kmt_pkg::*; #(
	parameter int SLOTS        = SLOTS_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	kmt_req_if.sink      req,
	kmt_rsp_if.source    rsp
);

	localparam int AW    = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int ENT_W = KEY_W + 1;

	// Entry memory holds {valid, key}; payload memory holds the contents
	logic [ENT_W-1:0]        ent_mem [SLOTS];
	logic [PAYLOAD_BITS-1:0] pay_mem [SLOTS];

	state_t state_q, state_d;

	logic [AW-1:0]           clr_addr_q;
	logic [AW-1:0]           scan_addr_q;
	logic                    issue_on_q;
	logic                    cmp_vld_s1;
	logic                    cmp_last_s1;
	logic [AW-1:0]           cmp_idx_s1;
	logic [ENT_W-1:0]        ent_rd_s1;
	logic                    hit_q;
	logic [AW-1:0]           hit_idx_q;
	logic                    free_q;
	logic [AW-1:0]           free_idx_q;
	logic [CNT_W-1:0]        occ_q;

	kind_t                   kind_q;
	logic [KEY_W-1:0]        key_q;
	logic                    marker_q;
	logic [PAYLOAD_BITS-1:0] pay_in_q;
	logic [PAYLOAD_BITS-1:0] pay_rd_s1;
	status_t                 res_status_q;

	logic                    rsp_valid_q;
	status_t                 rsp_status_q;
	logic [DATA_W-1:0]       rsp_payload_q;
	logic [COUNT_W-1:0]      rsp_vcnt_q;
	logic [COUNT_W-1:0]      rsp_fcnt_q;

	logic                    in_ready;
	logic                    in_fire;
	logic                    ent_we;
	logic [AW-1:0]           ent_wa;
	logic [ENT_W-1:0]        ent_wd;
	logic                    pay_we;
	logic [AW-1:0]           pay_wa;
	status_t                 dec_status;
	logic                    occ_inc;
	logic                    occ_dec;
	logic                    load_out;
	logic                    hit_ok;

	assign in_fire = req.valid && in_ready;
	assign hit_ok  = hit_q && !marker_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		ent_we     = 1'b0;
		ent_wa     = hit_idx_q;
		ent_wd     = {1'b0, key_q};
		pay_we     = 1'b0;
		pay_wa     = hit_idx_q;
		dec_status = ST_REJECTED;
		occ_inc    = 1'b0;
		occ_dec    = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			S_CLEAR: begin
				ent_we = 1'b1;
				ent_wa = clr_addr_q;
				ent_wd = '0;
				if (clr_addr_q == AW'(SLOTS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (req.valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (cmp_vld_s1 && cmp_last_s1) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				case (kind_q)
					K_ADD: begin
						if (marker_q) begin
							dec_status = ST_REJECTED;
						end else if (hit_q) begin
							dec_status = ST_UPDATED;
							pay_we     = 1'b1;
						end else if (free_q) begin
							dec_status = ST_INSERTED;
							ent_we     = 1'b1;
							ent_wa     = free_idx_q;
							ent_wd     = {1'b1, key_q};
							pay_we     = 1'b1;
							pay_wa     = free_idx_q;
							occ_inc    = 1'b1;
						end else begin
							dec_status = ST_FULL;
						end
					end
					K_GET: begin
						dec_status = hit_ok ? ST_FOUND : ST_NOT_FOUND;
					end
					K_REMOVE: begin
						if (hit_ok) begin
							dec_status = ST_REMOVED;
							ent_we     = 1'b1;
							occ_dec    = 1'b1;
						end else begin
							dec_status = ST_NOT_FOUND;
						end
					end
					default: begin
						dec_status = ST_REJECTED;
					end
				endcase
				state_d = S_RESP;
			end
			S_RESP: begin
				// hold until the response register is free
				if (!rsp_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			scan_addr_q <= '0;
			issue_on_q  <= 1'b0;
			cmp_vld_s1  <= 1'b0;
			cmp_last_s1 <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end

			if (in_fire) begin
				scan_addr_q <= '0;
				issue_on_q  <= 1'b1;
				hit_q       <= 1'b0;
				free_q      <= 1'b0;
			end else if (issue_on_q) begin
				scan_addr_q <= scan_addr_q + 1'b1;
				if (scan_addr_q == AW'(SLOTS - 1)) begin
					issue_on_q <= 1'b0;
				end
			end

			cmp_vld_s1  <= issue_on_q;
			cmp_last_s1 <= issue_on_q && (scan_addr_q == AW'(SLOTS - 1));

			// keep the first matching and the first empty slot
			if (cmp_vld_s1) begin
				if (ent_rd_s1[KEY_W] && ent_rd_s1[KEY_W-1:0] == key_q && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (!ent_rd_s1[KEY_W] && !free_q) begin
					free_q <= 1'b1;
				end
			end

			if (occ_inc) begin
				occ_q <= occ_q + 1'b1;
			end else if (occ_dec) begin
				occ_q <= occ_q - 1'b1;
			end

			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath and memories
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q   <= kind_t'(req.kind);
			key_q    <= req.key;
			marker_q <= req.key_is_empty_marker;
			pay_in_q <= PAYLOAD_BITS'(req.payload_in);
		end

		if (issue_on_q) begin
			ent_rd_s1  <= ent_mem[scan_addr_q];
			cmp_idx_s1 <= scan_addr_q;
		end

		if (cmp_vld_s1) begin
			if (ent_rd_s1[KEY_W] && ent_rd_s1[KEY_W-1:0] == key_q && !hit_q) begin
				hit_idx_q <= cmp_idx_s1;
			end
			if (!ent_rd_s1[KEY_W] && !free_q) begin
				free_idx_q <= cmp_idx_s1;
			end
		end

		if (ent_we) begin
			ent_mem[ent_wa] <= ent_wd;
		end
		if (pay_we) begin
			pay_mem[pay_wa] <= pay_in_q;
		end

		if (state_q == S_DECIDE) begin
			pay_rd_s1    <= pay_mem[hit_idx_q];
			res_status_q <= dec_status;
		end

		if (load_out) begin
			rsp_status_q  <= res_status_q;
			rsp_payload_q <= (res_status_q == ST_FOUND) ? DATA_W'(pay_rd_s1) : '0;
			rsp_vcnt_q    <= COUNT_W'(occ_q);
			rsp_fcnt_q    <= COUNT_W'(CNT_W'(SLOTS) - occ_q);
		end
	end

	assign req.ready       = in_ready;
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.payload_out = rsp_payload_q;
	assign rsp.valid_count = rsp_vcnt_q;
	assign rsp.free_count  = rsp_fcnt_q;

endmodule

// File: design/kmt_checker.sv
// ----------------------------------------------------------------------------
// kmt_checker
// Port-level checks of the keyed message table, bound into keyed_message_table_core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kmt_checker import kmt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] rsp_status,
	input logic [DATA_W-1:0]   rsp_payload_out,
	input logic [COUNT_W-1:0]  rsp_valid_count,
	input logic [COUNT_W-1:0]  rsp_free_count
);

	// one request at a time: no back-to-back acceptance
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req_valid && req_ready, !req_ready, "request accepted on consecutive cycles")

	`ASSERT_SAME(a_counts_sum, clk, arst_n, rsp_valid, COUNT_W'(rsp_valid_count + rsp_free_count) == COUNT_W'(SLOTS), "valid and free counts do not add up to capacity")

	`ASSERT_SAME(a_payload_zero, clk, arst_n, rsp_valid && rsp_status != ST_FOUND, rsp_payload_out == '0, "payload given without a successful get")

	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_payload_out), "stalled response changed")

endmodule

bind keyed_message_table_core kmt_checker #(.SLOTS(SLOTS)) u_kmt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_payload_out (rsp.payload_out),
	.rsp_valid_count (rsp.valid_count),
	.rsp_free_count  (rsp.free_count)
);
